[rtl/htld_pkg.sv]
// htld_pkg: shared types and constants for the tree-load decoder.
// No dependencies.
`timescale 1ns / 1ps
package htld_pkg;
  localparam int unsigned MaxNodesDef   = 512;
  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    ACT_TREE_BIT = 2'd0,
    ACT_TREE_END = 2'd1,
    ACT_DATA     = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_TREE_OK  = 2'd1,
    ST_TREE_BAD = 2'd2,
    ST_BAD_PATH = 2'd3
  } status_e;

  // One command from the front end to the back end.
  typedef struct packed {
    action_e    action;
    logic       tree_bit;
    logic [7:0] data_byte;
    logic [3:0] count;
  } cmd_t;
endpackage

[rtl/htld_front.sv]
// htld_front: accepts input items, drops unused codes, saturates bit counts,
// and queues commands for the back end. Depends on htld_pkg.
`timescale 1ns / 1ps
module htld_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic              tree_bit_i,
  input  logic [7:0]        data_byte_i,
  input  logic [3:0]        valid_bits_i,
  output logic              cmd_valid_o,
  input  logic              cmd_take_i,
  output htld_pkg::cmd_t    cmd_o
);
  localparam int unsigned Depth = htld_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  htld_pkg::cmd_t          mem_q [Depth];
  logic [PtrW-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]           cnt_q, cnt_d;
  logic                    push, pop, keep;
  htld_pkg::cmd_t          cmd_in;

  // Classify: action 3 is swallowed, count above 8 saturates.
  assign keep = (action_i != htld_pkg::ACT_UNUSED);
  always_comb begin
    cmd_in.action    = htld_pkg::action_e'(action_i);
    cmd_in.tree_bit  = tree_bit_i;
    cmd_in.data_byte = data_byte_i;
    cmd_in.count     = (valid_bits_i > 4'd8) ? 4'd8 : valid_bits_i;
  end

  assign in_stall_o  = (cnt_q == (PtrW+1)'(Depth));
  assign push        = in_valid_i && !in_stall_o && keep;
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_in;
  end
endmodule

[rtl/htld_back.sv]
// htld_back: tree builder and bit-serial tree walker with node tables in RAM.
// Depends on htld_pkg.
`timescale 1ns / 1ps
module htld_back #(
  parameter int unsigned MaxNodes   = htld_pkg::MaxNodesDef,
  parameter int unsigned StackDepth = htld_pkg::StackDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_take_o,
  input  htld_pkg::cmd_t    cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        symbol_o,
  output logic [1:0]        status_o,
  output logic              last_o
);
  localparam int unsigned NW = $clog2(MaxNodes);
  localparam int unsigned SW = $clog2(StackDepth);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BUILD = 7'b0000010,
    S_SREAD = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_LEAF  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [NW-1:0] left;
    logic [NW-1:0] right;
    logic          leaf;
    logic [7:0]    sym;
  } node_t;

  state_e           state_q;
  node_t            node_mem [MaxNodes];
  logic [NW:0]      stack_mem [StackDepth];

  // Builder state
  logic [SW:0]      lvl_q;
  logic [NW:0]      cnt_q;
  logic [7:0]       shf_q;
  logic [3:0]       sleft_q;
  logic             berr_q, ready_q;
  logic             leaf_pend_q;
  // Walker state
  logic [NW-1:0]    walk_q;
  logic [7:0]       byte_q;
  logic [3:0]       bits_q;
  logic [NW-1:0]    next_q;
  // Result held back until it is known whether it closes the item
  logic             pend_q;
  logic [7:0]       psym_q;
  logic [1:0]       pst_q;
  // Output register
  logic             ov_q;
  logic [7:0]       osym_q;
  logic [1:0]       ost_q;
  logic             olast_q;

  // Registered reads
  node_t            nrd_q;
  logic [NW:0]      srd_q;
  logic [NW-1:0]    nraddr;
  logic             out_free;

  // Build decode
  logic             top_right;
  logic [NW-1:0]    parent;
  logic             is_leaf_add;
  logic [SW:0]      lvl_after;
  logic             fault;
  logic [NW-1:0]    new_idx;

  // Walk decode
  logic             bit_now;
  logic [NW-1:0]    child;
  logic             fire;

  // Parent patch
  logic             patch_q;
  logic [NW-1:0]    patch_par_q, patch_child_q;
  logic             patch_right_q;
  logic [SW-1:0]    patch_slot_q;
  node_t            patch_rd_q;

  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign symbol_o    = osym_q;
  assign status_o    = ost_q;
  assign last_o      = olast_q;
  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i && out_free;

  assign bit_now = byte_q[7];
  assign child   = bit_now ? nrd_q.right : nrd_q.left;

  // Node read address: child while stepping, held child at leaf check,
  // otherwise the current walk node.
  always_comb begin
    if (state_q == S_WALK && child != '0) nraddr = child;
    else if (state_q == S_LEAF) nraddr = next_q;
    else nraddr = walk_q;
  end

  always_ff @(posedge clk_i) begin
    nrd_q <= node_mem[nraddr];
    srd_q <= stack_mem[lvl_q[SW-1:0] - 1'b1];
  end

  // Side bit of a stack entry sits in the top bit.
  assign top_right = srd_q[NW];
  assign parent    = srd_q[NW-1:0];
  always_comb begin
    lvl_after = lvl_q;
    if (cnt_q != '0 && top_right) lvl_after = lvl_q - 1'b1;
    fault = (cnt_q >= (NW+1)'(MaxNodes)) ||
            (cnt_q != '0 && lvl_q == '0) ||
            (!leaf_pend_q && lvl_after >= (SW+1)'(StackDepth));
  end
  assign is_leaf_add = leaf_pend_q;
  assign new_idx     = cnt_q[NW-1:0];

  // A result leaves whenever the output register is loaded.
  assign fire = (cmd_take_o && (cmd_i.action == htld_pkg::ACT_TREE_END ||
                                (cmd_i.action == htld_pkg::ACT_DATA && !ready_q))) ||
                (state_q == S_WALK && child == '0 && pend_q && out_free) ||
                (state_q == S_LEAF && nrd_q.leaf && pend_q && out_free) ||
                (state_q == S_FLUSH && pend_q && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (fire) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      cnt_q       <= '0;
      shf_q       <= '0;
      sleft_q     <= '0;
      berr_q      <= 1'b0;
      ready_q     <= 1'b0;
      leaf_pend_q <= 1'b0;
      walk_q      <= '0;
      bits_q      <= '0;
      byte_q      <= '0;
      next_q      <= '0;
      pend_q      <= 1'b0;
      psym_q      <= '0;
      pst_q       <= '0;
      osym_q      <= '0;
      ost_q       <= '0;
      olast_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            unique case (cmd_i.action)
              htld_pkg::ACT_TREE_BIT: begin
                ready_q <= 1'b0;
                walk_q  <= '0;
                if (!berr_q) begin
                  if (sleft_q != '0) begin
                    shf_q   <= {shf_q[6:0], cmd_i.tree_bit};
                    sleft_q <= sleft_q - 1'b1;
                    if (sleft_q == 4'd1) begin
                      leaf_pend_q <= 1'b1;
                      state_q     <= S_SREAD;
                    end
                  end else if (cmd_i.tree_bit) begin
                    sleft_q <= 4'd8;
                    shf_q   <= '0;
                  end else begin
                    leaf_pend_q <= 1'b0;
                    state_q     <= S_SREAD;
                  end
                end
              end
              htld_pkg::ACT_TREE_END: begin
                osym_q  <= '0;
                olast_q <= 1'b1;
                if (!berr_q && cnt_q != '0 && sleft_q == '0) begin
                  ost_q   <= htld_pkg::ST_TREE_OK;
                  ready_q <= 1'b1;
                end else begin
                  ost_q   <= htld_pkg::ST_TREE_BAD;
                  ready_q <= 1'b0;
                end
                lvl_q   <= '0;
                cnt_q   <= '0;
                shf_q   <= '0;
                sleft_q <= '0;
                berr_q  <= 1'b0;
                walk_q  <= '0;
              end
              htld_pkg::ACT_DATA: begin
                if (!ready_q) begin
                  osym_q  <= '0;
                  ost_q   <= htld_pkg::ST_BAD_PATH;
                  olast_q <= 1'b1;
                end else if (cmd_i.count != '0) begin
                  byte_q  <= cmd_i.data_byte;
                  bits_q  <= cmd_i.count;
                  state_q <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        // Stack top read is in flight; it lands next cycle.
        S_SREAD: state_q <= S_BUILD;
        S_BUILD: begin
          state_q <= S_IDLE;
          if (fault) berr_q <= 1'b1;
          else begin
            cnt_q <= cnt_q + 1'b1;
            lvl_q <= lvl_after + (SW+1)'(!is_leaf_add);
          end
        end
        // Node read of walk_q is valid here.
        S_WALK: begin
          if (child == '0) begin
            // Null child: hand over any held symbol, then the error closes the item.
            if (!pend_q || out_free) begin
              if (pend_q) begin
                osym_q  <= psym_q;
                ost_q   <= pst_q;
                olast_q <= 1'b0;
              end
              psym_q  <= '0;
              pst_q   <= htld_pkg::ST_BAD_PATH;
              pend_q  <= 1'b1;
              walk_q  <= '0;
              state_q <= S_FLUSH;
            end
          end else begin
            next_q  <= child;
            state_q <= S_LEAF;
          end
        end
        // Node read of next_q is valid here.
        S_LEAF: begin
          if (nrd_q.leaf) begin
            if (!pend_q || out_free) begin
              if (pend_q) begin
                osym_q  <= psym_q;
                ost_q   <= pst_q;
                olast_q <= 1'b0;
              end
              psym_q  <= nrd_q.sym;
              pst_q   <= htld_pkg::ST_SYMBOL;
              pend_q  <= 1'b1;
              walk_q  <= '0;
              state_q <= S_EMIT;
            end
          end else begin
            walk_q  <= next_q;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          byte_q  <= {byte_q[6:0], 1'b0};
          bits_q  <= bits_q - 1'b1;
          state_q <= (bits_q == 4'd1) ? S_FLUSH : S_WALK;
        end
        // Byte done or null child: the held result is the last one of the item.
        S_FLUSH: begin
          if (!pend_q) state_q <= S_IDLE;
          else if (out_free) begin
            osym_q  <= psym_q;
            ost_q   <= pst_q;
            olast_q <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Parent patch bookkeeping, captured in the build step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) patch_q <= 1'b0;
    else patch_q <= (state_q == S_BUILD) && !fault && (cnt_q != '0);
  end
  always_ff @(posedge clk_i) begin
    patch_par_q   <= parent;
    patch_child_q <= new_idx;
    patch_right_q <= top_right;
    patch_slot_q  <= lvl_q[SW-1:0] - 1'b1;
    patch_rd_q    <= node_mem[parent];
  end

  // Table writes: new node and push in the build step, parent link and
  // side bit in the cycle after.
  always_ff @(posedge clk_i) begin
    if (state_q == S_BUILD && !fault) begin
      node_mem[new_idx] <= '{left: '0, right: '0, leaf: is_leaf_add,
                             sym: is_leaf_add ? shf_q : 8'd0};
      if (!is_leaf_add) stack_mem[lvl_after[SW-1:0]] <= {1'b0, new_idx};
    end else if (patch_q) begin
      if (patch_right_q) begin
        node_mem[patch_par_q] <= '{left: patch_rd_q.left, right: patch_child_q,
                                   leaf: patch_rd_q.leaf, sym: patch_rd_q.sym};
      end else begin
        node_mem[patch_par_q] <= '{left: patch_child_q, right: patch_rd_q.right,
                                   leaf: patch_rd_q.leaf, sym: patch_rd_q.sym};
        stack_mem[patch_slot_q] <= {1'b1, patch_par_q};
      end
    end
  end
endmodule

[rtl/huffman_tree_load_decode.sv]
// huffman_tree_load_decode: top level, front queue plus build/walk back end.
// Depends on htld_pkg, htld_front, htld_back.
//
//  channel | handshake          | fields
//  in      | in_valid_i/stall_o | action_i tree_bit_i data_byte_i valid_bits_i
//  out     | out_valid_o/stall_i| symbol_o status_o last_o
//
// A tree bit that adds a node passes stack read, build and a parent patch that
// overlaps the next item; other tree bits are taken in the idle state alone.
// A data byte is taken in idle, walks each consumed bit by node read, child read
// and shift, and hands over the held-back final result in the flush state.
// Reset clears all control state; node and stack tables are undefined.
// A stalled output holds the back end at the next result; input queues 2 deep.
`timescale 1ns / 1ps
module huffman_tree_load_decode #(
  parameter int unsigned MaxNodes   = htld_pkg::MaxNodesDef,
  parameter int unsigned StackDepth = htld_pkg::StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic       tree_bit_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] valid_bits_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  logic           cmd_valid, cmd_take;
  htld_pkg::cmd_t cmd;

  htld_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .tree_bit_i,
    .data_byte_i, .valid_bits_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  htld_back #(.MaxNodes(MaxNodes), .StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .symbol_o, .status_o, .last_o
  );

  // A result whose status is not a symbol always carries a zero symbol.
  a_err_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != htld_pkg::ST_SYMBOL |-> symbol_o == 8'd0)
    else $error("nonzero symbol on error result");
  // Tree results always close their item.
  a_tree_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == htld_pkg::ST_TREE_OK ||
    status_o == htld_pkg::ST_TREE_BAD) |-> last_o)
    else $error("tree result without last");
  // Back end never takes a command the queue does not hold.
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");
endmodule
